// ===== sv/pnap_pkg.sv =====
// ----------------------------------------------------------------------------
// pnap_pkg
// shared types and constants for the polyline nearest arc parameter block
// ----------------------------------------------------------------------------
package pnap_pkg;

    localparam int RUN_W   = 48;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
    localparam logic [16:0]      FRAC_ONE = 17'h10000;

    localparam logic [0:0] REG_MIN_SEG = 1'b0;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
        logic               last_vertex;
    } vtx_t;

    typedef struct packed {
        logic [16:0] arc_fraction;
        logic        found;
    } res_t;

    // one queued command: a segment to project and/or the end of a polyline
    typedef struct packed {
        logic               has_seg;
        logic               last;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] wx;
        logic signed [32:0] wy;
    } seg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_SUM, ST_SQRT, ST_LEN,
        ST_DOT_X, ST_DOT_Y, ST_DOT_SUM, ST_T_SET, ST_DIV,
        ST_EX_M, ST_EY_M, ST_EY_S, ST_SQE_X, ST_SQE_Y, ST_ARC_M, ST_UPD,
        ST_FIN_SET, ST_FIN_DIV, ST_OUT
    } st_t;

    function automatic logic [MUL_W-1:0] mag35(input logic signed [34:0] v);
        logic [34:0] n;
        n = v[34] ? (35'd0 - 35'(v)) : 35'(v);
        return n[MUL_W-1:0];
    endfunction

endpackage

// ===== sv/pnap_fifo.sv =====
// ----------------------------------------------------------------------------
// pnap_fifo
// short queue of segment commands between front and back
// ----------------------------------------------------------------------------
module pnap_fifo
    import pnap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  seg_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output seg_t pop_data
);

    seg_t           mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign full      = (count_reg == (QAW+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/pnap_front.sv =====
// ----------------------------------------------------------------------------
// pnap_front
// takes vertex beats, holds the query and previous vertex, forms segment deltas
// ----------------------------------------------------------------------------
module pnap_front
    import pnap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic vtx_valid,
    output logic vtx_ready,
    input  vtx_t vtx,
    input  logic q_full,
    output logic push,
    output seg_t push_data
);

    logic signed [31:0] prev_x_reg, prev_y_reg, qx_reg, qy_reg;
    logic               have_prev_reg, have_prev_next;
    logic               accept;

    assign vtx_ready = !q_full;
    assign accept    = vtx_valid && vtx_ready;

    always_comb
    begin
        push_data.has_seg = have_prev_reg;
        push_data.last    = vtx.last_vertex;
        push_data.dx      = 33'(vtx.vertex_x) - 33'(prev_x_reg);
        push_data.dy      = 33'(vtx.vertex_y) - 33'(prev_y_reg);
        push_data.wx      = 33'(qx_reg) - 33'(prev_x_reg);
        push_data.wy      = 33'(qy_reg) - 33'(prev_y_reg);
        // a lone first vertex that is not last needs no work in the back
        push = accept && (have_prev_reg || vtx.last_vertex);
        have_prev_next = have_prev_reg;
        if (accept)
        begin
            have_prev_next = !vtx.last_vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_x_reg <= vtx.vertex_x;
            prev_y_reg <= vtx.vertex_y;
            if (!have_prev_reg)
            begin
                qx_reg <= vtx.query_x;
                qy_reg <= vtx.query_y;
            end
        end
    end

endmodule

// ===== sv/pnap_back.sv =====
// ----------------------------------------------------------------------------
// pnap_back
// sequencer around one shared multiplier: length, projection, distance, result
// ----------------------------------------------------------------------------
module pnap_back
    import pnap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] min_seg,
    input  logic        q_not_empty,
    input  seg_t        q_data,
    output logic        q_pop,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    st_t state_reg, state_next;

    seg_t               cur_reg;
    logic [PROD_W-1:0]  prod_reg, acc_reg;
    logic signed [68:0] dot_reg;
    logic [65:0]        segsq_reg;
    logic [PROD_W-1:0]  op_reg, root_reg, one_reg;
    logic [32:0]        seglen_reg, t_reg;
    logic [RUN_W-1:0]   start_reg, running_reg, best_arc_reg;
    logic [PROD_W-1:0]  rem_reg;
    logic signed [34:0] ex_reg, ey_reg;
    logic [63:0]        dist_reg, best_dist_reg;
    logic               found_reg;
    logic [5:0]         cnt_reg;
    logic [16:0]        frac_reg;
    logic [RUN_W:0]     frem_reg;
    logic               out_valid_reg;
    res_t               out_reg;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  trial, rem2;
    logic [PROD_W:0]    sq_sum;
    logic [RUN_W:0]     run_sum, arc_sum, frem2;
    logic [32:0]        scaled;
    logic signed [34:0] sc_signed;
    logic               skip, take;
    logic               dot_neg;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_X:  begin mul_a = mag35(35'(cur_reg.dx)); mul_b = mul_a; end
            ST_SQ_Y:  begin mul_a = mag35(35'(cur_reg.dy)); mul_b = mul_a; end
            ST_DOT_X:
            begin
                mul_a = mag35(35'(cur_reg.wx));
                mul_b = mag35(35'(cur_reg.dx));
            end
            ST_DOT_Y:
            begin
                mul_a = mag35(35'(cur_reg.wy));
                mul_b = mag35(35'(cur_reg.dy));
            end
            ST_EX_M:  begin mul_a = mag35(35'(cur_reg.dx)); mul_b = MUL_W'(t_reg); end
            ST_EY_M:  begin mul_a = mag35(35'(cur_reg.dy)); mul_b = MUL_W'(t_reg); end
            ST_SQE_X: begin mul_a = mag35(ex_reg); mul_b = mul_a; end
            ST_SQE_Y: begin mul_a = mag35(ey_reg); mul_b = mul_a; end
            ST_ARC_M: begin mul_a = MUL_W'(t_reg); mul_b = MUL_W'(seglen_reg); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        sq_sum    = (PROD_W+1)'(acc_reg) + (PROD_W+1)'(prod_reg);
        trial     = root_reg + one_reg;
        rem2      = {rem_reg[PROD_W-2:0], 1'b0};
        run_sum   = (RUN_W+1)'(running_reg) + (RUN_W+1)'(root_reg[32:0]);
        arc_sum   = (RUN_W+1)'(start_reg) + (RUN_W+1)'(prod_reg[67:32]);
        frem2     = {frem_reg[RUN_W-1:0], 1'b0};
        scaled    = prod_reg[64:32];
        // sign of the delta that was just scaled by t
        sc_signed = (state_reg == ST_EY_M) ?
                    (cur_reg.dx[32] ? -35'(scaled) : 35'(scaled)) :
                    (cur_reg.dy[32] ? -35'(scaled) : 35'(scaled));
        skip      = (root_reg[32:0] < 33'(min_seg)) || (segsq_reg == '0);
        take      = !found_reg || (dist_reg < best_dist_reg);
        dot_neg   = (state_reg == ST_DOT_Y) ? (cur_reg.wx[32] ^ cur_reg.dx[32]) :
                                              (cur_reg.wy[32] ^ cur_reg.dy[32]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    if (q_data.has_seg)       state_next = ST_SQ_X;
                    else if (q_data.last)     state_next = ST_FIN_SET;
                end
            end
            ST_SQ_X:    state_next = ST_SQ_Y;
            ST_SQ_Y:    state_next = ST_SQ_SUM;
            ST_SQ_SUM:  state_next = ST_SQRT;
            ST_SQRT:    if (cnt_reg == '0) state_next = ST_LEN;
            ST_LEN:
            begin
                if (!skip)             state_next = ST_DOT_X;
                else if (cur_reg.last) state_next = ST_FIN_SET;
                else                   state_next = ST_IDLE;
            end
            ST_DOT_X:   state_next = ST_DOT_Y;
            ST_DOT_Y:   state_next = ST_DOT_SUM;
            ST_DOT_SUM: state_next = ST_T_SET;
            ST_T_SET:
            begin
                if (dot_reg > 69'sd0 && 69'(segsq_reg) > dot_reg) state_next = ST_DIV;
                else                                              state_next = ST_EX_M;
            end
            ST_DIV:     if (cnt_reg == '0) state_next = ST_EX_M;
            ST_EX_M:    state_next = ST_EY_M;
            ST_EY_M:    state_next = ST_EY_S;
            ST_EY_S:    state_next = ST_SQE_X;
            ST_SQE_X:   state_next = ST_SQE_Y;
            ST_SQE_Y:   state_next = ST_ARC_M;
            ST_ARC_M:   state_next = ST_UPD;
            ST_UPD:     state_next = cur_reg.last ? ST_FIN_SET : ST_IDLE;
            ST_FIN_SET:
            begin
                if (found_reg && running_reg != '0 && best_arc_reg < running_reg)
                    state_next = ST_FIN_DIV;
                else
                    state_next = ST_OUT;
            end
            ST_FIN_DIV: if (cnt_reg == '0) state_next = ST_OUT;
            ST_OUT:     if (!out_valid_reg || res_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            running_reg   <= '0;
            best_arc_reg  <= '0;
            best_dist_reg <= '1;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_valid_reg || res_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LEN:
                begin
                    running_reg <= run_sum[RUN_W] ? RUN_MAX : run_sum[RUN_W-1:0];
                end
                ST_UPD:
                begin
                    if (take)
                    begin
                        found_reg     <= 1'b1;
                        best_dist_reg <= dist_reg;
                        best_arc_reg  <= arc_sum[RUN_W] ? RUN_MAX : arc_sum[RUN_W-1:0];
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || res_ready)
                    begin
                        found_reg     <= 1'b0;
                        running_reg   <= '0;
                        best_arc_reg  <= '0;
                        best_dist_reg <= '1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg <= q_data;
            end
            ST_SQ_Y:
            begin
                acc_reg <= prod_reg;
            end
            ST_SQ_SUM:
            begin
                segsq_reg <= sq_sum[65:0];
                op_reg    <= sq_sum[PROD_W-1:0];
                root_reg  <= '0;
                one_reg   <= PROD_W'(1) << 64;
                cnt_reg   <= 6'd32;
            end
            ST_SQRT:
            begin
                // one result bit of the integer square root per cycle
                if (op_reg >= trial)
                begin
                    op_reg   <= op_reg - trial;
                    root_reg <= (root_reg >> 1) + one_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                one_reg <= one_reg >> 2;
                cnt_reg <= cnt_reg - 6'd1;
            end
            ST_LEN:
            begin
                seglen_reg <= root_reg[32:0];
                start_reg  <= running_reg;
            end
            ST_DOT_Y:
            begin
                dot_reg <= dot_neg ? -69'(prod_reg) : 69'(prod_reg);
            end
            ST_DOT_SUM:
            begin
                dot_reg <= dot_neg ? dot_reg - 69'(prod_reg) : dot_reg + 69'(prod_reg);
            end
            ST_T_SET:
            begin
                rem_reg <= PROD_W'(dot_reg);
                cnt_reg <= 6'd31;
                if (dot_reg <= 69'sd0)
                    t_reg <= '0;
                else if (dot_reg >= 69'(segsq_reg))
                    t_reg <= 33'h1_0000_0000;
                else
                    t_reg <= '0;
            end
            ST_DIV:
            begin
                if (rem2 >= PROD_W'(segsq_reg))
                begin
                    rem_reg <= rem2 - PROD_W'(segsq_reg);
                    t_reg   <= {t_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2;
                    t_reg   <= {t_reg[31:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
            ST_EY_M:
            begin
                ex_reg <= sc_signed - 35'(cur_reg.wx);
            end
            ST_EY_S:
            begin
                ey_reg <= sc_signed - 35'(cur_reg.wy);
            end
            ST_SQE_Y:
            begin
                acc_reg <= prod_reg;
            end
            ST_ARC_M:
            begin
                dist_reg <= (sq_sum[PROD_W:64] != '0) ? '1 : sq_sum[63:0];
            end
            ST_FIN_SET:
            begin
                frem_reg <= (RUN_W+1)'(best_arc_reg);
                cnt_reg  <= 6'd15;
                if (!found_reg || running_reg == '0)
                    frac_reg <= '0;
                else if (best_arc_reg >= running_reg)
                    frac_reg <= FRAC_ONE;
                else
                    frac_reg <= '0;
            end
            ST_FIN_DIV:
            begin
                if (frem2 >= (RUN_W+1)'(running_reg))
                begin
                    frem_reg <= frem2 - (RUN_W+1)'(running_reg);
                    frac_reg <= {frac_reg[15:0], 1'b1};
                end
                else
                begin
                    frem_reg <= frem2;
                    frac_reg <= {frac_reg[15:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_reg.arc_fraction <= frac_reg;
                    out_reg.found        <= found_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sv/polyline_nearest_arc_parameter.sv =====
// ----------------------------------------------------------------------------
// polyline_nearest_arc_parameter
// arc-length fraction of the point on a streamed polyline nearest a query
// ----------------------------------------------------------------------------
// channel  direction  payload  handshake
// vtx      in         vtx_t    vtx_valid / vtx_ready
// res      out        res_t    res_valid / res_ready
// cfg      in         32 bit   apb write/read, pready tied high
//
// each segment runs through the back sequencer: the square root, a t divide
// when 0 < t < 1, and one shared 34x34 multiplier used nine times; a last
// vertex may add a fraction divide.
// the front takes a vertex beat each cycle while the 4-entry queue has room.
// a result waiting in the output register stalls only the back.
// rst_n clears control state asynchronously.
// ----------------------------------------------------------------------------
module polyline_nearest_arc_parameter
    import pnap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vtx_valid,
    output logic        vtx_ready,
    input  vtx_t        vtx,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] min_seg_reg;
    logic        q_full, q_push, q_pop, q_not_empty;
    seg_t        q_in, q_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_SEG) ? {16'd0, min_seg_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_seg_reg <= 16'd1;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_MIN_SEG)
        begin
            min_seg_reg <= pwdata[15:0];
        end
    end

    pnap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_in)
    );

    pnap_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    pnap_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .min_seg     (min_seg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

endmodule

// ===== sv/pnap_checker.sv =====
// ----------------------------------------------------------------------------
// pnap_checker
// port-level checks on the result channel and config port
// ----------------------------------------------------------------------------
module pnap_checker
    import pnap_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input res_t res,
    input logic pready
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result beat during reset");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result beat changed");

    a_zero_if_none: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.found |-> res.arc_fraction == 17'd0)
        else $error("nonzero fraction without a found segment");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.arc_fraction <= FRAC_ONE)
        else $error("fraction above one");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind polyline_nearest_arc_parameter pnap_checker u_pnap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .pready    (pready)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// polyline nearest arc parameter testbench
// streams polylines through the block with random idling and back-pressure,
// predicts each arc fraction in a scoreboard and compares every result beat
// ----------------------------------------------------------------------------
module testbench;
    import pnap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] LEN_MAX = {48{1'b1}};

    class arc_scoreboard;
        logic [15:0] min_seg;
        longint      prev_x, prev_y, query_x, query_y;
        bit          have_prev, any_found;
        logic [47:0] run_len, best_arc;
        logic [63:0] best_dsq;
        res_t        pending[$];
        int          errors;

        function new();
            min_seg = 16'd1;
            prev_x = 0;
            prev_y = 0;
            query_x = 0;
            query_y = 0;
            errors = 0;
            clear_run();
        endfunction

        function void clear_run();
            have_prev = 0;
            any_found = 0;
            run_len = '0;
            best_arc = '0;
            best_dsq = '1;
        endfunction

        function logic [47:0] add_sat(logic [47:0] a, logic [127:0] b);
            logic [127:0] s;
            s = {80'd0, a} + b;
            return (s > {80'd0, LEN_MAX}) ? LEN_MAX : s[47:0];
        endfunction

        function logic [63:0] floor_sqrt(logic [127:0] n);
            logic [63:0]  root;
            logic [127:0] cand;
            root = '0;
            for (int b = 32; b >= 0; b--) begin
                cand = {64'd0, root | (64'd1 << b)};
                if (cand * cand <= n)
                    root = cand[63:0];
            end
            return root;
        endfunction

        function logic signed [127:0] scale_by_t(logic signed [127:0] d,
                                                 logic signed [127:0] t);
            if (d < 0)
                return -(((-d) * t) >>> 32);
            return (d * t) >>> 32;
        endfunction

        function void project_segment(longint vx, longint vy);
            logic signed [127:0] dx, dy, wx, wy, seg_sq, dot, t, ex, ey, dsq;
            logic [127:0]        along;
            logic [63:0]         seg_len, dist_sat;
            logic [47:0]         start;
            dx = vx - prev_x;
            dy = vy - prev_y;
            wx = query_x - prev_x;
            wy = query_y - prev_y;
            seg_sq = dx * dx + dy * dy;
            seg_len = floor_sqrt(seg_sq);
            start = run_len;
            run_len = add_sat(run_len, {64'd0, seg_len});
            // zero-length segments are skipped even with a zero threshold
            if (seg_len < {48'd0, min_seg} || seg_sq == 0)
                return;
            dot = wx * dx + wy * dy;
            if (dot <= 0)
                t = 0;
            else if (dot >= seg_sq)
                t = 128'sd1 <<< 32;
            else
                t = (dot <<< 32) / seg_sq;
            ex = scale_by_t(dx, t) - wx;
            ey = scale_by_t(dy, t) - wy;
            dsq = ex * ex + ey * ey;
            dist_sat = (dsq[127:64] != 0) ? '1 : dsq[63:0];
            if (!any_found || dist_sat < best_dsq) begin
                any_found = 1;
                best_dsq = dist_sat;
                along = (t * $signed({64'd0, seg_len})) >>> 32;
                best_arc = add_sat(start, along);
            end
        endfunction

        function void note_vertex(vtx_t v);
            res_t        r;
            logic [63:0] frac;
            if (!have_prev) begin
                query_x = v.query_x;
                query_y = v.query_y;
                have_prev = 1;
            end
            else begin
                project_segment(v.vertex_x, v.vertex_y);
            end
            prev_x = v.vertex_x;
            prev_y = v.vertex_y;
            if (!v.last_vertex)
                return;
            frac = '0;
            if (any_found && run_len != 0) begin
                frac = {best_arc, 16'd0} / {16'd0, run_len};
                if (frac > 64'(FRAC_ONE))
                    frac = 64'(FRAC_ONE);
            end
            r.arc_fraction = frac[16:0];
            r.found = any_found;
            pending = {pending, r};
            clear_run();
        endfunction

        function void check_result(res_t r);
            res_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat, got fraction %0d found %0d",
                         $realtime, r.arc_fraction, r.found);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (r.arc_fraction !== want.arc_fraction) begin
                $display("%0t: arc_fraction expected %0d actual %0d",
                         $realtime, want.arc_fraction, r.arc_fraction);
                errors++;
            end
            if (r.found !== want.found) begin
                $display("%0t: found expected %0d actual %0d",
                         $realtime, want.found, r.found);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        vtx_valid;
    logic        vtx_ready;
    vtx_t        vtx;
    logic        res_valid;
    logic        res_ready;
    res_t        res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    arc_scoreboard sb;
    int            idle_pct;
    int            stall_pct;
    int            sent;
    longint        last_x, last_y;

    polyline_nearest_arc_parameter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vtx_valid(vtx_valid),
        .vtx_ready(vtx_ready),
        .vtx      (vtx),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null) begin
            if (vtx_valid && vtx_ready)
                sb.note_vertex(vtx);
            if (res_valid && res_ready)
                sb.check_result(res);
        end
    end

    task automatic write_min_seg(logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MIN_SEG, 2'b00};
        pwdata <= {16'($urandom_range(65535)), 16'd0} | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.min_seg = value;
    endtask

    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] qx, logic signed [31:0] qy,
                               logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 20)
            gap++;
        if (gap > 0) begin
            vtx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vtx_valid <= 1'b1;
        vtx <= '{x, y, qx, qy, last};
        @(posedge clk);
        while (!vtx_ready)
            @(posedge clk);
        last_x = x;
        last_y = y;
        sent++;
    endtask

    function automatic logic signed [31:0] pick_coord(int scale, longint near);
        case (scale)
            0: return $urandom();
            1: return 32'(near + $signed(32'($urandom_range(1 << 20))) - (1 << 19));
            default: return 32'(near + $signed(32'($urandom_range(8))) - 4);
        endcase
    endfunction

    // well-formed polyline with random content; scale picks the coordinate spread
    task automatic random_polyline(int count);
        int                 scale;
        logic signed [31:0] x, y;
        scale = $urandom_range(2);
        x = $urandom();
        y = $urandom();
        for (int i = 0; i < count; i++) begin
            if (i > 0 && $urandom_range(9) == 0) begin
                x = last_x;
                y = last_y;
            end
            else if (i > 0) begin
                x = pick_coord(scale, last_x);
                y = pick_coord(scale, last_y);
            end
            send_vertex(x, y, pick_coord(scale, x), pick_coord(scale, y),
                        i == count - 1);
        end
    endtask

    task automatic wait_drained();
        vtx_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        vtx_valid = 1'b0;
        vtx = '0;
        res_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        last_x = 0;
        last_y = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // single vertex, then extremes with t clamped low and high
        send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b1);
        send_vertex(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b1);
        send_vertex(0, 0, -32'sd100, 0, 1'b0);
        send_vertex(32'sd1000, 0, 0, 0, 1'b0);
        send_vertex(32'sd2000, 0, 0, 0, 1'b1);
        send_vertex(0, 0, 32'sd5000, 32'sd7, 1'b0);
        send_vertex(32'sd1000, 0, 0, 0, 1'b1);
        // zero-length segment only, and a tie between two segments
        send_vertex(32'sd5, 32'sd5, 0, 0, 1'b0);
        send_vertex(32'sd5, 32'sd5, 0, 0, 1'b1);
        send_vertex(-32'sd100, 0, 0, 32'sd100, 1'b0);
        send_vertex(0, 0, 0, 0, 1'b0);
        send_vertex(32'sd100, 0, 0, 0, 1'b1);
        wait_drained();

        write_min_seg(16'd0);
        send_vertex(32'sd3, 32'sd3, 0, 0, 1'b0);
        send_vertex(32'sd3, 32'sd3, 0, 0, 1'b0);
        send_vertex(32'sd4, 32'sd3, 0, 0, 1'b1);
        wait_drained();

        write_min_seg(16'hffff);
        send_vertex(0, 0, 32'sd10, 32'sd10, 1'b0);
        send_vertex(32'sd100, 0, 0, 0, 1'b0);
        send_vertex(32'sd100, 32'sd70000, 0, 0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  write_min_seg(16'd0); end
                1: begin idle_pct = 77; stall_pct = 0;  write_min_seg(16'hffff); end
                2: begin idle_pct = 0;  stall_pct = 77; write_min_seg(16'($urandom())); end
                default: begin idle_pct = 21; stall_pct = 21; write_min_seg(16'd1); end
            endcase
            sent = 0;
            while (sent < 95) begin
                if ($urandom_range(7) == 0)
                    send_vertex($urandom(), $urandom(), $urandom(), $urandom(),
                                $urandom_range(3) == 0);
                else
                    random_polyline($urandom_range(1, 8));
            end
            // close any polyline a noise beat left open
            send_vertex($urandom(), $urandom(), $urandom(), $urandom(), 1'b1);
            wait_drained();
        end

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== polyline_nearest_arc_parameter.f =====
sv/pnap_pkg.sv
sv/pnap_fifo.sv
sv/pnap_front.sv
sv/pnap_back.sv
sv/polyline_nearest_arc_parameter.sv
sv/pnap_checker.sv
bench/testbench.sv
